// ===== sv/smpq_pkg.sv =====
package smpq_pkg;

  localparam int KEY_W = 32;
  localparam int OUT_CNT_W = 5;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_POP_EMPTY  = 2'd1,
    ERR_PUSH_FULL  = 2'd2,
    ERR_RSVD       = 2'd3
  } err_t;

  // Shift command broadcast to every cell in the row.
  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [KEY_W-1:0] key;
  } shift_ctrl_t;

endpackage

// ===== sv/sorted_min_priority_queue.sv =====
// out_valid pulses the cycle after start is taken.
// Throughput: one word per cycle; busy stays low, since every cell compares
// the key with its own entry and shifts in the same cycle.
// Reset (rst_n low, synchronous) empties the queue and clears out_valid.
// The receiver cannot stall: each result shows for exactly one cycle.
module sorted_min_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_opcode,
  input  logic signed [smpq_pkg::KEY_W-1:0] in_key,
  output logic                              out_valid,
  output logic signed [smpq_pkg::KEY_W-1:0] out_top_key,
  output logic                              out_empty_res,
  output logic [smpq_pkg::OUT_CNT_W-1:0]    out_entry_count,
  output logic [1:0]                        out_error_code
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]                   count_r;
  logic [CNT_W-1:0]                   count_nxt;
  logic [CNT_W+smpq_pkg::OUT_CNT_W-1:0] count_ext;
  smpq_pkg::shift_ctrl_t              ctrl;
  smpq_pkg::err_t                     err;
  logic                               full;
  logic                               empty;
  logic signed [smpq_pkg::KEY_W-1:0]  top_nxt;

  logic signed [smpq_pkg::KEY_W-1:0]  entries [CAPACITY];
  logic                               stays   [CAPACITY];

  assign busy  = 1'b0;
  assign full  = count_r == CNT_W'(CAPACITY);
  assign empty = count_r == '0;

  always_comb begin
    ctrl.key  = in_key;
    ctrl.push = 1'b0;
    ctrl.pop  = 1'b0;
    err       = smpq_pkg::ERR_OK;
    count_nxt = count_r;
    if (start) begin
      unique case (smpq_pkg::op_t'(in_opcode))
        smpq_pkg::OP_PUSH: begin
          if (full) begin
            err = smpq_pkg::ERR_PUSH_FULL;
          end else begin
            ctrl.push = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        smpq_pkg::OP_POP: begin
          if (empty) begin
            err = smpq_pkg::ERR_POP_EMPTY;
          end else begin
            ctrl.pop  = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        default: err = smpq_pkg::ERR_OK;
      endcase
    end
  end

  // smallest key after the operation, taken from the cells' current entries
  always_comb begin
    priority if (count_nxt == '0) begin
      top_nxt = '0;
    end else if (ctrl.push) begin
      top_nxt = (empty || (in_key < entries[0])) ? in_key : entries[0];
    end else if (ctrl.pop) begin
      top_nxt = entries[1];
    end else begin
      top_nxt = entries[0];
    end
  end

  assign count_ext = {{smpq_pkg::OUT_CNT_W{1'b0}}, count_nxt};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                              l_stay;
    logic signed [smpq_pkg::KEY_W-1:0] l_entry;
    logic signed [smpq_pkg::KEY_W-1:0] r_entry;

    if (i == 0) begin : g_head
      // head cell takes the new key whenever it does not keep its own
      assign l_stay  = 1'b1;
      assign l_entry = in_key;
    end else begin : g_body
      assign l_stay  = stays[i-1];
      assign l_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_entry = in_key;
    end else begin : g_mid
      assign r_entry = entries[i+1];
    end

    smpq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count_r),
      .left_stay   (l_stay),
      .left_entry  (l_entry),
      .right_entry (r_entry),
      .stay        (stays[i]),
      .entry       (entries[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      out_valid <= start;
    end
    out_top_key     <= top_nxt;
    out_empty_res   <= count_nxt == '0;
    out_entry_count <= count_ext[smpq_pkg::OUT_CNT_W-1:0];
    out_error_code  <= err;
  end

endmodule

// ===== sv/smpq_cell.sv =====
module smpq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                              clk,
  input  smpq_pkg::shift_ctrl_t             ctrl,
  input  logic [CNT_W-1:0]                  count,
  input  logic                              left_stay,
  input  logic signed [smpq_pkg::KEY_W-1:0] left_entry,
  input  logic signed [smpq_pkg::KEY_W-1:0] right_entry,
  output logic                              stay,
  output logic signed [smpq_pkg::KEY_W-1:0] entry
);

  logic signed [smpq_pkg::KEY_W-1:0] entry_r;
  logic signed [smpq_pkg::KEY_W-1:0] entry_nxt;
  logic                              occ;

  assign occ   = count > CNT_W'(IDX);
  // keep the entry when it is at or below the new key, so ties stay in arrival order
  assign stay  = occ && (entry_r <= ctrl.key);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push) begin
      priority if (stay) begin
        entry_nxt = entry_r;
      end else if (left_stay) begin
        entry_nxt = ctrl.key;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
